// ----- sv/ihc_pkg.sv -----
`timescale 1ns / 1ps

package ihc_pkg;

  localparam int unsigned HDR_BYTES = 20;
  localparam int unsigned POS_W = 5;

  localparam logic [POS_W-1:0] POS_VER_IHL   = 5'd0;
  localparam logic [POS_W-1:0] POS_TOT_LEN   = 5'd3;
  localparam logic [POS_W-1:0] POS_IDENT     = 5'd5;
  localparam logic [POS_W-1:0] POS_FLAGS_OFF = 5'd7;
  localparam logic [POS_W-1:0] POS_TTL       = 5'd8;
  localparam logic [POS_W-1:0] POS_PROTO     = 5'd9;
  localparam logic [POS_W-1:0] POS_CHECKSUM  = 5'd11;
  localparam logic [POS_W-1:0] POS_SRC_FIRST = 5'd12;
  localparam logic [POS_W-1:0] POS_SRC_LAST  = 5'd15;
  localparam logic [POS_W-1:0] POS_DST_FIRST = 5'd16;
  localparam logic [POS_W-1:0] POS_DST_LAST  = 5'd19;
  localparam logic [POS_W-1:0] POS_END       = POS_W'(HDR_BYTES);

  localparam logic [1:0] VERDICT_ACCEPTED   = 2'd0;
  localparam logic [1:0] VERDICT_BAD_CSUM   = 2'd1;
  localparam logic [1:0] VERDICT_NOT_FOR_ME = 2'd2;
  localparam logic [1:0] VERDICT_UNUSED     = 2'd3;

  localparam logic [1:0] FRAG_NONE   = 2'd0;
  localparam logic [1:0] FRAG_FIRST  = 2'd1;
  localparam logic [1:0] FRAG_MIDDLE = 2'd2;
  localparam logic [1:0] FRAG_LAST   = 2'd3;

  localparam logic [1:0] CLASS_ICMP  = 2'd0;
  localparam logic [1:0] CLASS_TCP   = 2'd1;
  localparam logic [1:0] CLASS_UDP   = 2'd2;
  localparam logic [1:0] CLASS_OTHER = 2'd3;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  localparam int unsigned MF_BIT = 13;

  typedef struct packed {
    logic [15:0] ones_sum;
    logic [7:0]  version_ihl;
    logic [15:0] total_length;
    logic [15:0] ident;
    logic [15:0] flags_offset;
    logic [7:0]  ttl;
    logic [7:0]  proto;
    logic [15:0] stored_checksum;
    logic [31:0] src;
    logic [31:0] dst;
  } hdr_fields_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic [1:0]  fragment_kind;
    logic [1:0]  payload_class;
    logic [15:0] ident;
    logic [15:0] fragment_byte_offset;
    logic [15:0] payload_length;
    logic [5:0]  header_length_bytes;
    logic [7:0]  time_to_live;
    logic [7:0]  protocol_number;
    logic [31:0] source_address;
  } result_t;

  function automatic logic [15:0] oc_add(input logic [15:0] acc, input logic [15:0] word);
    logic [16:0] s;
    s = {1'b0, acc} + {1'b0, word};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

// ----- sv/ihc_accum.sv -----
`timescale 1ns / 1ps

module ihc_accum
  import ihc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  logic [7:0]  header_byte,
  input  logic        start_of_header,
  input  logic        release_hdr,
  output logic        done,
  output hdr_fields_t fields
);

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_eff;
  logic [15:0]      sum_eff;
  logic [7:0]       odd_high_byte;
  logic [15:0]      word;
  logic             in_header;

  assign pos_eff   = start_of_header ? '0 : pos;
  assign sum_eff   = start_of_header ? 16'd0 : fields.ones_sum;
  assign word      = {odd_high_byte, header_byte};
  assign in_header = pos_eff < POS_END;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos           <= '0;
      odd_high_byte <= 8'd0;
      fields        <= '0;
      done          <= 1'b0;
    end else begin
      if (release_hdr) begin
        done <= 1'b0;
      end
      if (take) begin
        if (in_header) begin
          pos <= pos_eff + 5'd1;
          if (pos_eff == POS_DST_LAST) begin
            done <= 1'b1;
          end
          if (!pos_eff[0] || pos_eff == POS_CHECKSUM) begin
            fields.ones_sum <= sum_eff;
          end else begin
            fields.ones_sum <= oc_add(sum_eff, word);
          end
          if (!pos_eff[0]) begin
            odd_high_byte <= header_byte;
          end
          unique case (pos_eff) inside
            POS_VER_IHL:   fields.version_ihl     <= header_byte;
            POS_TOT_LEN:   fields.total_length    <= word;
            POS_IDENT:     fields.ident           <= word;
            POS_FLAGS_OFF: fields.flags_offset    <= word;
            POS_TTL:       fields.ttl             <= header_byte;
            POS_PROTO:     fields.proto           <= header_byte;
            POS_CHECKSUM:  fields.stored_checksum <= word;
            [POS_SRC_FIRST:POS_SRC_LAST]: fields.src <= {fields.src[23:0], header_byte};
            [POS_DST_FIRST:POS_DST_LAST]: fields.dst <= {fields.dst[23:0], header_byte};
            default: ;
          endcase
        end else begin
          pos <= pos_eff;
        end
      end
    end
  end

endmodule

// ----- sv/ihc_result.sv -----
`timescale 1ns / 1ps

module ihc_result
  import ihc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  logic        out_ready,
  input  logic [31:0] my_address,
  input  hdr_fields_t fields,
  output logic        out_valid,
  output result_t     result
);

  result_t     result_next;
  logic [5:0]  hl;
  logic [15:0] off;

  always_comb begin
    hl  = {fields.version_ihl[3:0], 2'b00};
    off = {fields.flags_offset[12:0], 3'b000};

    result_next.ident                = fields.ident;
    result_next.fragment_byte_offset = off;
    result_next.payload_length       = fields.total_length - {10'd0, hl};
    result_next.header_length_bytes  = hl;
    result_next.time_to_live         = fields.ttl;
    result_next.protocol_number      = fields.proto;
    result_next.source_address       = fields.src;

    if (~fields.ones_sum != fields.stored_checksum) begin
      result_next.verdict = VERDICT_BAD_CSUM;
    end else if (fields.dst != my_address) begin
      result_next.verdict = VERDICT_NOT_FOR_ME;
    end else begin
      result_next.verdict = VERDICT_ACCEPTED;
    end

    if (fields.flags_offset[MF_BIT]) begin
      result_next.fragment_kind = (off == 16'd0) ? FRAG_FIRST : FRAG_MIDDLE;
    end else begin
      result_next.fragment_kind = (off == 16'd0) ? FRAG_NONE : FRAG_LAST;
    end

    case (fields.proto)
      PROTO_ICMP: result_next.payload_class = CLASS_ICMP;
      PROTO_TCP:  result_next.payload_class = CLASS_TCP;
      PROTO_UDP:  result_next.payload_class = CLASS_UDP;
      default:    result_next.payload_class = CLASS_OTHER;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= result_next;
    end
  end

endmodule

// ----- sv/ipv4_header_checker_core.sv -----
`timescale 1ns / 1ps
// IPv4 header checker. Header bytes enter on the input channel (in_valid,
// in_ready) one per transfer in wire order, with start_of_header marking
// byte 0. After the twentieth byte one verdict with the decoded header
// fields leaves on the output channel (out_valid, out_ready). Bytes past the
// twentieth without a start mark are taken and dropped.
// The user must write the own address through cfg_write_enable and
// cfg_write_data only while the block is idle; the block does not enforce
// this. The written address takes effect at the next clock edge. Throughput
// is one byte per cycle while in_ready is high. The accumulator captures the
// last header byte at its transfer edge; the result register, which holds
// the checksum compare and field decode, loads from it when free and raises
// out_valid. When the receiver stalls, the result register holds its
// transfer and one finished header waits in the accumulator; only when both
// are full does in_ready drop. Synchronous reset clears the byte count, the
// running sum and captured fields, both valid flags and the own address.

module ipv4_header_checker_core
  import ihc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  header_byte,
  input  logic        start_of_header,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  verdict,
  output logic [1:0]  fragment_kind,
  output logic [1:0]  payload_class,
  output logic [15:0] ident,
  output logic [15:0] fragment_byte_offset,
  output logic [15:0] payload_length,
  output logic [5:0]  header_length_bytes,
  output logic [7:0]  time_to_live,
  output logic [7:0]  protocol_number,
  output logic [31:0] source_address,
  input  logic        cfg_write_enable,
  input  logic [31:0] cfg_write_data
);

  logic [31:0] my_address;
  logic        done;
  logic        load;
  logic        take;
  hdr_fields_t fields;
  result_t     result;

  always_ff @(posedge clk) begin
    if (rst) begin
      my_address <= 32'd0;
    end else if (cfg_write_enable) begin
      my_address <= cfg_write_data;
    end
  end

  assign load     = done && (!out_valid || out_ready);
  assign in_ready = !done || load;
  assign take     = in_valid && in_ready;

  ihc_accum u_accum (
    .clk             (clk),
    .rst             (rst),
    .take            (take),
    .header_byte     (header_byte),
    .start_of_header (start_of_header),
    .release_hdr     (load),
    .done            (done),
    .fields          (fields)
  );

  ihc_result u_result (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .out_ready  (out_ready),
    .my_address (my_address),
    .fields     (fields),
    .out_valid  (out_valid),
    .result     (result)
  );

  assign verdict              = result.verdict;
  assign fragment_kind        = result.fragment_kind;
  assign payload_class        = result.payload_class;
  assign ident                = result.ident;
  assign fragment_byte_offset = result.fragment_byte_offset;
  assign payload_length       = result.payload_length;
  assign header_length_bytes  = result.header_length_bytes;
  assign time_to_live         = result.time_to_live;
  assign protocol_number      = result.protocol_number;
  assign source_address       = result.source_address;

endmodule

// ----- sv/ihc_checker.sv -----
`timescale 1ns / 1ps

module ihc_checker
  import ihc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  verdict,
  input logic [15:0] fragment_byte_offset,
  input logic [5:0]  header_length_bytes
);

  // Input stalls only while a result transfer is itself stalled.
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("in_ready low without a stalled result");

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("out_valid set after reset");

  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (verdict != VERDICT_UNUSED))
    else $error("undefined verdict code");

  a_field_scaling: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (fragment_byte_offset[2:0] == 3'd0 && header_length_bytes[1:0] == 2'd0))
    else $error("offset or header length not scaled");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(verdict)))
    else $error("stalled result changed");

endmodule

bind ipv4_header_checker_core ihc_checker u_ihc_checker (.*);
